### sv/b64lw_pkg.sv
`default_nettype none

package b64lw_pkg;

  // Characters other than the alphabet
  localparam logic [7:0] CHAR_CR  = 8'h0D;
  localparam logic [7:0] CHAR_LF  = 8'h0A;
  localparam logic [7:0] CHAR_PAD = 8'h3D;

  // Line length register
  localparam int unsigned GPL_W = 6;
  localparam logic [GPL_W-1:0] GPL_RESET = 6'd15;

  // Longest run of characters one input beat can cause
  localparam int unsigned RUN_MAX = 8;
  localparam int unsigned RUN_CNT_W = $clog2(RUN_MAX + 1);
  localparam int unsigned RUN_IDX_W = $clog2(RUN_MAX);

  typedef logic [7:0] char_t;

  // Map a six-bit symbol onto the base64 alphabet
  function automatic char_t b64_char(input logic [5:0] sym);
    char_t c;
    c = 8'h2F;
    if (sym < 6'd26) begin
      c = 8'h41 + {2'b00, sym};
    end else if (sym < 6'd52) begin
      c = 8'h61 + {2'b00, sym - 6'd26};
    end else if (sym < 6'd62) begin
      c = 8'h30 + {2'b00, sym - 6'd52};
    end else if (sym == 6'd62) begin
      c = 8'h2B;
    end
    return c;
  endfunction

endpackage

`default_nettype wire

### sv/base64_encoder_line_wrap_top.sv
// The first character of a beat's run is shown in the cycle after the beat is taken.
// Throughput: one character per cycle while out_ready_i is high; run length 0 to 8,
// set by the eight-entry run shift register draining one per accepted output beat.
// The next input beat is taken in the cycle the last character of a run is taken.
// Reset (rst_ni low, asynchronous): empty run, no held bytes, line count zero,
// groups_per_line back to 15.
`default_nettype none

module base64_encoder_line_wrap_top (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  // input beats
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [7:0] data_byte_i,
  input  wire logic       has_byte_i,
  input  wire logic       end_of_input_i,
  // output characters
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [7:0]      out_char_o,
  output logic            last_of_run_o,
  output logic            stream_done_o,
  // configuration
  input  wire logic       cfg_valid_i,
  output logic            cfg_ready_o,
  input  wire logic [b64lw_pkg::GPL_W-1:0] cfg_data_i
);

  localparam int unsigned N = b64lw_pkg::RUN_MAX;

  logic [b64lw_pkg::GPL_W-1:0]     gpl_q;
  logic [15:0]                     held_q, held_d;
  logic [1:0]                      nb_q, nb_d;
  logic [b64lw_pkg::GPL_W-1:0]     gol_q, gol_d;

  b64lw_pkg::char_t                run_q [N];
  b64lw_pkg::char_t                run_d [N];
  logic [b64lw_pkg::RUN_CNT_W-1:0] cnt_q, cnt_d;
  logic                            fin_q, fin_d;

  logic                            in_beat, out_beat;
  logic                            full_grp, pad_grp, grp, wrap;
  logic [15:0]                     held_mid;
  logic [1:0]                      nb_mid;
  logic [23:0]                     word;
  logic [b64lw_pkg::GPL_W-1:0]     gol_inc;
  logic [b64lw_pkg::RUN_IDX_W-1:0] k;
  b64lw_pkg::char_t                nrun [N];
  logic [b64lw_pkg::RUN_CNT_W-1:0] ncnt;

  assign cfg_ready_o = 1'b1;

  // Handshakes: take a new beat once the current run is drained or draining
  assign out_valid_o = (cnt_q != '0);
  assign out_beat    = out_valid_o && out_ready_i;
  assign in_ready_o  = !out_valid_o || (out_ready_i && (cnt_q == 1));
  assign in_beat     = in_valid_i && in_ready_o;

  assign out_char_o    = run_q[0];
  assign last_of_run_o = out_valid_o && (cnt_q == 1);
  assign stream_done_o = last_of_run_o && fin_q;

  // Work out the byte holding and group selection for one beat
  always_comb begin
    full_grp = has_byte_i && nb_q[1];
    held_mid = held_q;
    nb_mid   = nb_q;
    if (has_byte_i) begin
      case (nb_q)
        2'd0:    begin held_mid = {data_byte_i, 8'h00};     nb_mid = 2'd1; end
        2'd1:    begin held_mid = {held_q[15:8], data_byte_i}; nb_mid = 2'd2; end
        default: begin held_mid = 16'h0000;                 nb_mid = 2'd0; end
      endcase
    end
    pad_grp = end_of_input_i && (nb_mid != 2'd0);
    grp     = full_grp || pad_grp;
    word    = full_grp ? {held_q, data_byte_i} : {held_mid, 8'h00};
    gol_inc = gol_q + 1'b1;
    wrap    = grp && (gol_inc == gpl_q);
  end

  // Assemble the run: group, line break, closing line break
  always_comb begin
    for (int i = 0; i < N; i++) begin
      nrun[i] = b64lw_pkg::CHAR_LF;
    end
    nrun[0] = b64lw_pkg::b64_char(word[23:18]);
    nrun[1] = b64lw_pkg::b64_char(word[17:12]);
    nrun[2] = (pad_grp && nb_mid == 2'd1) ? b64lw_pkg::CHAR_PAD
                                          : b64lw_pkg::b64_char(word[11:6]);
    nrun[3] = pad_grp ? b64lw_pkg::CHAR_PAD : b64lw_pkg::b64_char(word[5:0]);
    k = '0;
    if (grp) begin
      k = b64lw_pkg::RUN_IDX_W'(4);
    end
    if (wrap) begin
      nrun[4] = b64lw_pkg::CHAR_CR;
      nrun[5] = b64lw_pkg::CHAR_LF;
      k = b64lw_pkg::RUN_IDX_W'(6);
    end
    if (end_of_input_i) begin
      nrun[k]      = b64lw_pkg::CHAR_CR;
      nrun[k + 1'b1] = b64lw_pkg::CHAR_LF;
    end
    ncnt = b64lw_pkg::RUN_CNT_W'({grp, 2'b00})
         + b64lw_pkg::RUN_CNT_W'({wrap, 1'b0})
         + b64lw_pkg::RUN_CNT_W'({end_of_input_i, 1'b0});
  end

  // Next state: load a fresh run on an input beat, else shift on an output beat
  always_comb begin
    held_d = held_q;
    nb_d   = nb_q;
    gol_d  = gol_q;
    run_d  = run_q;
    cnt_d  = cnt_q;
    fin_d  = fin_q;
    if (out_beat) begin
      for (int i = 0; i < N - 1; i++) begin
        run_d[i] = run_q[i + 1];
      end
      cnt_d = cnt_q - 1'b1;
    end
    if (in_beat) begin
      run_d = nrun;
      cnt_d = ncnt;
      fin_d = end_of_input_i;
      if (end_of_input_i) begin
        held_d = 16'h0000;
        nb_d   = 2'd0;
        gol_d  = '0;
      end else begin
        held_d = held_mid;
        nb_d   = nb_mid;
        if (grp) begin
          gol_d = wrap ? '0 : gol_inc;
        end
      end
    end
  end

  // Hold control state and the line register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gpl_q  <= b64lw_pkg::GPL_RESET;
      held_q <= 16'h0000;
      nb_q   <= 2'd0;
      gol_q  <= '0;
      cnt_q  <= '0;
      fin_q  <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        gpl_q <= cfg_data_i;
      end
      held_q <= held_d;
      nb_q   <= nb_d;
      gol_q  <= gol_d;
      cnt_q  <= cnt_d;
      fin_q  <= fin_d;
    end
  end

  // Run characters are payload: no reset
  always_ff @(posedge clk_i) begin
    run_q <= run_d;
  end

endmodule

`default_nettype wire

### sv/b64lw_checker.sv
`default_nettype none

module b64lw_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_ready_o,
  input wire logic       out_valid_o,
  input wire logic       out_ready_i,
  input wire logic [7:0] out_char_o,
  input wire logic       last_of_run_o,
  input wire logic       stream_done_o
);

  // Stalled output beat holds its character
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_char_o))
    else $error("stalled output character changed");

  // Input is only blocked by a pending run
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("input blocked with no run pending");

  // End of stream is the last LF of its run
  a_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && stream_done_o |-> last_of_run_o && out_char_o == b64lw_pkg::CHAR_LF)
    else $error("stream end not on closing LF");

  // A CR is always followed at once by its LF
  a_crlf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && out_char_o == b64lw_pkg::CHAR_CR
      |=> out_valid_o && out_char_o == b64lw_pkg::CHAR_LF)
    else $error("CR not followed by LF");

endmodule

bind base64_encoder_line_wrap_top b64lw_checker u_b64lw_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_ready_o    (in_ready_o),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .out_char_o    (out_char_o),
  .last_of_run_o (last_of_run_o),
  .stream_done_o (stream_done_o)
);

`default_nettype wire

### verif/b64lw_checker.sv
`timescale 1ns / 1ps

module b64lw_tb_checker (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  input  wire logic                        in_ready_i,
  input  wire logic [7:0]                  data_byte_i,
  input  wire logic                        has_byte_i,
  input  wire logic                        end_of_input_i,
  input  wire logic                        out_valid_i,
  input  wire logic                        out_ready_i,
  input  wire logic [7:0]                  out_char_i,
  input  wire logic                        last_of_run_i,
  input  wire logic                        stream_done_i,
  input  wire logic                        cfg_valid_i,
  input  wire logic                        cfg_ready_i,
  input  wire logic [b64lw_pkg::GPL_W-1:0] cfg_data_i,
  output int unsigned                      err_count_o,
  output int unsigned                      pending_o,
  output int unsigned                      chars_checked_o,
  output int unsigned                      streams_closed_o
);

  localparam logic [8*64-1:0] B64_SYMBOLS =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
    logic       done;
  } enc_char_t;

  // Encoder state as the predictor sees it
  logic [b64lw_pkg::GPL_W-1:0] line_len_q;
  logic [b64lw_pkg::GPL_W-1:0] line_cnt_q;
  logic [15:0]                 held_q;
  logic [1:0]                  held_n_q;

  enc_char_t run_buf[$];
  enc_char_t exp_chars[$];

  function automatic logic [7:0] symbol_char(input logic [5:0] s);
    return B64_SYMBOLS[8*(63 - int'(s)) +: 8];
  endfunction

  task automatic report_mismatch(input string field, input logic [7:0] got,
                                 input logic [7:0] want);
    $display("[%0t] mismatch on character %0d: %s is 0x%02h, expected 0x%02h",
             $realtime, chars_checked_o, field, got, want);
    err_count_o++;
  endtask

  task automatic push_char(input logic [7:0] c, input logic done);
    enc_char_t e;
    e.ch   = c;
    e.last = 1'b0;
    e.done = done;
    run_buf.push_back(e);
  endtask

  // Count a finished group and break the line when the count meets the register
  task automatic close_group();
    line_cnt_q = line_cnt_q + 1'b1;
    if (line_cnt_q == line_len_q) begin
      line_cnt_q = '0;
      push_char(b64lw_pkg::CHAR_CR, 1'b0);
      push_char(b64lw_pkg::CHAR_LF, 1'b0);
    end
  endtask

  // Work out the run of characters one input beat causes
  task automatic encode_beat(input logic [7:0] b, input logic has, input logic eoi);
    logic [7:0] b0;
    logic [7:0] b1;
    logic [1:0] n;
    enc_char_t  tail;
    run_buf.delete();
    b0 = held_q[15:8];
    b1 = held_q[7:0];
    n  = held_n_q;
    if (has) begin
      if (n == 2'd2) begin
        push_char(symbol_char(b0[7:2]), 1'b0);
        push_char(symbol_char({b0[1:0], b1[7:4]}), 1'b0);
        push_char(symbol_char({b1[3:0], b[7:6]}), 1'b0);
        push_char(symbol_char(b[5:0]), 1'b0);
        close_group();
        n      = 2'd0;
        held_q = '0;
      end else if (n == 2'd1) begin
        held_q = {b0, b};
        n      = 2'd2;
      end else begin
        held_q = {b, 8'h00};
        n      = 2'd1;
      end
      held_n_q = n;
    end
    if (eoi) begin
      b0 = held_q[15:8];
      b1 = held_q[7:0];
      // Pad out a partial group, then close the stream
      if (n == 2'd1) begin
        push_char(symbol_char(b0[7:2]), 1'b0);
        push_char(symbol_char({b0[1:0], 4'b0000}), 1'b0);
        push_char(b64lw_pkg::CHAR_PAD, 1'b0);
        push_char(b64lw_pkg::CHAR_PAD, 1'b0);
        close_group();
      end else if (n == 2'd2) begin
        push_char(symbol_char(b0[7:2]), 1'b0);
        push_char(symbol_char({b0[1:0], b1[7:4]}), 1'b0);
        push_char(symbol_char({b1[3:0], 2'b00}), 1'b0);
        push_char(b64lw_pkg::CHAR_PAD, 1'b0);
        close_group();
      end
      push_char(b64lw_pkg::CHAR_CR, 1'b0);
      push_char(b64lw_pkg::CHAR_LF, 1'b1);
      held_q     = '0;
      held_n_q   = '0;
      line_cnt_q = '0;
    end
    // Flag the last character of the run
    if (run_buf.size() > 0) begin
      tail      = run_buf.pop_back();
      tail.last = 1'b1;
      run_buf.push_back(tail);
    end
    foreach (run_buf[i]) exp_chars.push_back(run_buf[i]);
  endtask

  // Compare one handed-over character with the oldest expectation
  task automatic check_char();
    enc_char_t want;
    if (exp_chars.size() == 0) begin
      report_mismatch("unexpected character", out_char_i, 8'h00);
      return;
    end
    want = exp_chars.pop_front();
    if (out_char_i !== want.ch)
      report_mismatch("out_char", out_char_i, want.ch);
    if (last_of_run_i !== want.last)
      report_mismatch("last_of_run", {7'd0, last_of_run_i}, {7'd0, want.last});
    if (stream_done_i !== want.done)
      report_mismatch("stream_done", {7'd0, stream_done_i}, {7'd0, want.done});
    chars_checked_o++;
    if (want.done) streams_closed_o++;
  endtask

  // Retire characters first: a new beat is taken on the edge its predecessor ends
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_len_q = b64lw_pkg::GPL_RESET;
      line_cnt_q = '0;
      held_q     = '0;
      held_n_q   = '0;
      exp_chars.delete();
    end else begin
      if (out_valid_i && out_ready_i) check_char();
      if (in_valid_i && in_ready_i) encode_beat(data_byte_i, has_byte_i, end_of_input_i);
      if (cfg_valid_i && cfg_ready_i) line_len_q = cfg_data_i;
    end
    pending_o = exp_chars.size();
  end

endmodule

### verif/tb.sv
`timescale 1ns / 1ps

module tb;

  localparam int unsigned RUN_LIMIT   = 200000;
  localparam int unsigned PHASE_BEATS = 16;

  typedef enum logic [1:0] {
    RX_OPEN,
    RX_COIN,
    RX_SPARSE,
    RX_SLOW_BURSTS
  } rx_mode_e;

  logic                        clk_i          = 1'b0;
  logic                        rst_ni         = 1'b0;
  logic                        in_valid_i     = 1'b0;
  logic                        in_ready_o;
  logic [7:0]                  data_byte_i    = 8'h00;
  logic                        has_byte_i     = 1'b0;
  logic                        end_of_input_i = 1'b0;
  logic                        out_valid_o;
  logic                        out_ready_i    = 1'b0;
  logic [7:0]                  out_char_o;
  logic                        last_of_run_o;
  logic                        stream_done_o;
  logic                        cfg_valid_i    = 1'b0;
  logic                        cfg_ready_o;
  logic [b64lw_pkg::GPL_W-1:0] cfg_data_i     = '0;

  int unsigned err_count;
  int unsigned chars_pending;
  int unsigned chars_checked;
  int unsigned streams_closed;

  int unsigned cycle_cnt   = 0;
  int unsigned beats_sent  = 0;
  int unsigned data_beats  = 0;
  int unsigned cfg_writes  = 0;
  int unsigned burst_left  = 1;
  int unsigned leftover    = 0;
  bit          steady_send = 1'b0;

  logic [7:0] stall_tick = '0;
  rx_mode_e   rx_mode    = RX_OPEN;

  base64_encoder_line_wrap_top u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .data_byte_i    (data_byte_i),
    .has_byte_i     (has_byte_i),
    .end_of_input_i (end_of_input_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_char_o     (out_char_o),
    .last_of_run_o  (last_of_run_o),
    .stream_done_o  (stream_done_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i)
  );

  b64lw_tb_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_i       (in_ready_o),
    .data_byte_i      (data_byte_i),
    .has_byte_i       (has_byte_i),
    .end_of_input_i   (end_of_input_i),
    .out_valid_i      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .out_char_i       (out_char_o),
    .last_of_run_i    (last_of_run_o),
    .stream_done_i    (stream_done_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_i      (cfg_ready_o),
    .cfg_data_i       (cfg_data_i),
    .err_count_o      (err_count),
    .pending_o        (chars_pending),
    .chars_checked_o  (chars_checked),
    .streams_closed_o (streams_closed)
  );

  always #10 clk_i = ~clk_i;

  // Receiver stalls: switch pattern whenever the low six bits of stall_tick wrap to zero
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      stall_tick <= stall_tick + 1'b1;
      if (stall_tick[5:0] == 6'd0) rx_mode <= rx_mode_e'($urandom_range(0, 3));
      case (rx_mode)
        RX_OPEN:   out_ready_i <= 1'b1;
        RX_COIN:   out_ready_i <= 1'($urandom_range(0, 1));
        RX_SPARSE: out_ready_i <= ($urandom_range(0, 3) == 0);
        default:   out_ready_i <= stall_tick[3];
      endcase
    end
  end

  // Hard stop on a hung run
  initial begin
    while (cycle_cnt < RUN_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("FAIL");
    $finish;
  end

  // Gap between bursts, unless the sender is held steady
  task automatic pace_sender();
    int unsigned gap;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 10);
      gap = steady_send ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  // Present one beat and hold it until it is taken
  task automatic send_beat(input logic [7:0] b, input logic has, input logic eoi);
    in_valid_i     <= 1'b1;
    data_byte_i    <= b;
    has_byte_i     <= has;
    end_of_input_i <= eoi;
    do @(posedge clk_i); while (!in_ready_o);
    beats_sent++;
    if (has || eoi) data_beats++;
    pace_sender();
  endtask

  // Drop valid and wait until every predicted character has come out
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (chars_pending != 0);
    // an idle beat may still be in flight
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_line_len(input logic [b64lw_pkg::GPL_W-1:0] groups);
    wait_drained();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= groups;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    cfg_writes++;
  endtask

  // One stream of random bytes, closed on the last byte or by a bare flush
  task automatic send_random_stream();
    int unsigned len;
    int unsigned pick;
    bit          bare_flush;
    pick = $urandom_range(0, 99);
    if (pick < 8)       len = 0;
    else if (pick < 65) len = $urandom_range(1, 6);
    else if (pick < 92) len = $urandom_range(7, 30);
    else                len = $urandom_range(31, 40);
    bare_flush = (len == 0) || ($urandom_range(0, 2) == 0);
    for (int i = 0; i < int'(len); i++) begin
      if ($urandom_range(0, 19) == 0) send_beat(8'($urandom), 1'b0, 1'b0);
      send_beat(8'($urandom), 1'b1, !bare_flush && (i == int'(len) - 1));
    end
    if (bare_flush) send_beat(8'($urandom), 1'b0, 1'b1);
  endtask

  task automatic random_phase(input logic [b64lw_pkg::GPL_W-1:0] groups, input bit steady);
    int unsigned target;
    int unsigned pick;
    write_line_len(groups);
    steady_send = steady;
    target = data_beats + PHASE_BEATS;
    while (data_beats < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 80)
        send_random_stream();
      else if (pick < 95)
        send_beat(8'($urandom), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      else
        wait_drained();
    end
    steady_send = 1'b0;
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: line length at its reset value
    send_beat(8'hA5, 1'b0, 1'b1);   // empty stream
    send_beat(8'hFF, 1'b0, 1'b0);   // idle beat
    send_beat(8'h00, 1'b1, 1'b1);   // one byte, double pad
    send_beat(8'hFF, 1'b1, 1'b0);
    send_beat(8'hFF, 1'b1, 1'b1);   // two bytes, single pad
    send_beat(8'h00, 1'b1, 1'b0);
    send_beat(8'hFF, 1'b1, 1'b0);
    send_beat(8'h80, 1'b1, 1'b0);
    send_beat(8'h5A, 1'b0, 1'b1);   // flush with nothing held
    send_beat(8'hFB, 1'b1, 1'b0);
    send_beat(8'h00, 1'b0, 1'b0);
    send_beat(8'hEF, 1'b1, 1'b0);
    send_beat(8'h3C, 1'b0, 1'b1);   // flush with two held
    send_beat(8'h7E, 1'b1, 1'b0);
    send_beat(8'hC3, 1'b0, 1'b1);   // flush with one held
    send_beat(8'h14, 1'b1, 1'b0);
    send_beat(8'hFB, 1'b1, 1'b0);
    send_beat(8'hFF, 1'b1, 1'b1);   // full group ends the stream

    // Directed: one group per line, so a full line closes with two breaks
    write_line_len(6'd1);
    send_beat(8'h4D, 1'b1, 1'b0);
    send_beat(8'h61, 1'b1, 1'b0);
    send_beat(8'h6E, 1'b1, 1'b1);
    send_beat(8'h01, 1'b1, 1'b0);
    send_beat(8'h02, 1'b1, 1'b0);
    send_beat(8'h03, 1'b1, 1'b0);
    send_beat(8'hFE, 1'b1, 1'b1);

    // Build up 30 groups on a long line, then drop the register to zero below
    // the count: the break comes only when the counter wraps at 64 groups
    write_line_len(6'd40);
    for (int i = 0; i < 90; i++) send_beat(8'($urandom), 1'b1, 1'b0);
    write_line_len(6'd0);
    for (int i = 0; i < 103; i++) send_beat(8'($urandom), 1'b1, i == 102);

    // Random streams over a spread of line lengths
    random_phase(6'd2, 1'b0);
    random_phase(6'd3, 1'b1);
    random_phase(b64lw_pkg::GPL_RESET, 1'b0);

    // Drain, then let the tail settle
    in_valid_i <= 1'b0;
    begin
      int unsigned spins;
      spins = 0;
      do begin
        @(negedge clk_i);
        spins++;
      end while (chars_pending != 0 && spins < 5000);
    end
    repeat (16) @(posedge clk_i);
    @(negedge clk_i);
    leftover = chars_pending;
    if (leftover != 0) $display("%0d expected characters never came out", leftover);

    $display("Sent %0d beats (%0d carrying data or end) across %0d line-length writes.",
             beats_sent, data_beats, cfg_writes);
    $display("Checked %0d characters, %0d streams closed, %0d mismatches.",
             chars_checked, streams_closed, err_count);
    if (err_count == 0 && leftover == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
